>>> design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge, muted while reset is held.
`define PICC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define PICC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/picc_pkg.sv
package picc_pkg;

	typedef enum logic [1:0] {
		ST_ANSWERED = 2'd0,
		ST_STORED   = 2'd1,
		ST_FULL     = 2'd2,
		ST_TOO_LONG = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DRAIN
	} state_t;

endpackage

>>> design/picc_ram.sv
module picc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> design/path_interval_containment_cache_unit.sv
// Insert node: never raises busy; the result of a last node shows in the cycle after its transfer.
// Query node: busy through the sweep and a drain state, one stored entry compared per
// cycle from the store memories' registered read port; the result of a last node shows
// in the same cycle that busy falls. With no stored entries, or past the node limit, a
// query node is done like an insert node. arst_n resets counters, flags and sequencer
// at once; the stores hold no valid bits and need no clearing pass.
module path_interval_containment_cache_unit import picc_pkg::*; #(
	parameter int ENTRIES    = 64,
	parameter int MAX_NODES  = 16,
	parameter int POINT_BITS = 16,
	parameter int TIME_BITS  = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic                  command,
	input  logic [POINT_BITS-1:0] point_id,
	input  logic [TIME_BITS-1:0]  time_min,
	input  logic [TIME_BITS-1:0]  time_max,
	input  logic                  last,
	output logic                  done,
	output logic                  hit,
	output logic [1:0]            status
);

	// Widths: entry index, entry count (0..ENTRIES), node index, node count (0..MAX_NODES)
	localparam int EW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CW  = $clog2(ENTRIES + 1);
	localparam int PW  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
	localparam int PCW = $clog2(MAX_NODES + 1);
	// Node stores are addressed {entry, node}
	localparam int NODE_DEPTH = ENTRIES * (2 ** PW);
	localparam int NAW        = EW + PW;

	// Sequencer
	state_t state_q, state_d;
	logic   scan_issue;

	// Control state
	logic [CW-1:0]      count_q;
	logic [PCW-1:0]     pos_q;
	logic               too_long_q;
	logic [ENTRIES-1:0] flags_q;
	logic               done_q;
	logic [EW-1:0]      scan_e_q;
	logic               hit_acc_q;
	logic               cmp_v_s1;

	// Captured node of a query being swept
	logic [POINT_BITS-1:0] pid_q;
	logic [TIME_BITS-1:0]  tmin_q;
	logic [TIME_BITS-1:0]  tmax_q;
	logic [PW-1:0]         p_q;
	logic                  last_q;
	logic [EW-1:0]         cmp_e_s1;

	// Result registers
	logic    hit_q;
	status_t status_q;

	// Memory ports
	logic                  node_we;
	logic [NAW-1:0]        node_waddr;
	logic [NAW-1:0]        node_raddr;
	logic [POINT_BITS-1:0] pt_rd;
	logic [TIME_BITS-1:0]  min_rd;
	logic [TIME_BITS-1:0]  max_rd;
	logic                  len_we;
	logic [PCW-1:0]        len_wdata;
	logic [PCW-1:0]        len_rd;

	// Per-transfer decode
	logic accept;
	logic p_ok;
	logic full;
	logic too_long_n;
	logic need_scan;
	logic stored;
	logic scan_end;

	// Compare stage
	logic keep;
	logic hit_now;

	assign accept     = start && !busy;
	assign p_ok       = pos_q < PCW'(MAX_NODES);
	assign full       = count_q >= CW'(ENTRIES);
	assign too_long_n = too_long_q || !p_ok;
	// A query node narrows the flags only when it fits and something is stored
	assign need_scan  = command && p_ok && (count_q != '0);
	assign stored     = !command && last && !too_long_n && !full;
	assign scan_end   = (CW'(scan_e_q) + CW'(1)) == count_q;

	// Insert nodes go straight into the row of the next free entry
	assign node_we    = accept && !command && p_ok && !full;
	assign node_waddr = {count_q[EW-1:0], pos_q[PW-1:0]};
	assign node_raddr = {scan_e_q, p_q};
	assign len_we     = accept && stored;
	assign len_wdata  = pos_q + PCW'(1);

	picc_ram #(.WIDTH(POINT_BITS), .DEPTH(NODE_DEPTH)) u_point_ram (
		.clk   (clk),
		.we    (node_we),
		.waddr (node_waddr),
		.wdata (point_id),
		.raddr (node_raddr),
		.rdata (pt_rd)
	);

	picc_ram #(.WIDTH(TIME_BITS), .DEPTH(NODE_DEPTH)) u_min_ram (
		.clk   (clk),
		.we    (node_we),
		.waddr (node_waddr),
		.wdata (time_min),
		.raddr (node_raddr),
		.rdata (min_rd)
	);

	picc_ram #(.WIDTH(TIME_BITS), .DEPTH(NODE_DEPTH)) u_max_ram (
		.clk   (clk),
		.we    (node_we),
		.waddr (node_waddr),
		.wdata (time_max),
		.raddr (node_raddr),
		.rdata (max_rd)
	);

	picc_ram #(.WIDTH(PCW), .DEPTH(ENTRIES)) u_len_ram (
		.clk   (clk),
		.we    (len_we),
		.waddr (count_q[EW-1:0]),
		.wdata (len_wdata),
		.raddr (scan_e_q),
		.rdata (len_rd)
	);

	// Entry survives if it is longer than this position, same point, window contained
	assign keep = flags_q[cmp_e_s1] && (len_rd > PCW'(p_q)) && (pt_rd == pid_q) &&
		(tmin_q >= min_rd) && (tmax_q <= max_rd);
	// On the final node the entry must also end exactly here
	assign hit_now = cmp_v_s1 && last_q && keep && (len_rd == (PCW'(p_q) + PCW'(1)));

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept && need_scan) begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				if (scan_end) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Sequencer outputs
	always_comb begin
		busy       = 1'b1;
		scan_issue = 1'b0;
		case (state_q)
			S_IDLE: begin
				busy = 1'b0;
			end
			S_SCAN: begin
				scan_issue = 1'b1;
			end
			S_DRAIN: begin
				scan_issue = 1'b0;
			end
			default: begin
				busy = 1'b0;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			count_q    <= '0;
			pos_q      <= '0;
			too_long_q <= 1'b0;
			flags_q    <= '1;
			done_q     <= 1'b0;
			scan_e_q   <= '0;
			hit_acc_q  <= 1'b0;
			cmp_v_s1   <= 1'b0;
		end else begin
			state_q  <= state_d;
			// Strobe: a last node with no sweep, or the end of a last node's sweep
			done_q   <= (accept && last && !need_scan) || (state_q == S_DRAIN && last_q);
			cmp_v_s1 <= scan_issue;

			if (accept) begin
				if (last) begin
					// End of path: position and length mark back to reset
					pos_q      <= '0;
					too_long_q <= 1'b0;
					if (!need_scan) begin
						flags_q <= '1;
					end
				end else begin
					too_long_q <= too_long_n;
					if (p_ok) begin
						pos_q <= pos_q + PCW'(1);
					end
				end
				if (stored) begin
					count_q <= count_q + CW'(1);
				end
				scan_e_q  <= '0;
				hit_acc_q <= 1'b0;
			end

			if (scan_issue) begin
				scan_e_q <= scan_e_q + EW'(1);
			end

			// Query path over: every entry a candidate again
			if (state_q == S_DRAIN && last_q) begin
				flags_q <= '1;
			end else if (cmp_v_s1 && !keep) begin
				flags_q[cmp_e_s1] <= 1'b0;
			end

			if (cmp_v_s1) begin
				if (hit_now) begin
					hit_acc_q <= 1'b1;
				end
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		cmp_e_s1 <= scan_e_q;
		if (accept) begin
			pid_q  <= point_id;
			tmin_q <= time_min;
			tmax_q <= time_max;
			p_q    <= pos_q[PW-1:0];
			last_q <= last;
			if (command) begin
				hit_q    <= 1'b0;
				status_q <= ST_ANSWERED;
			end else if (too_long_n) begin
				hit_q    <= 1'b0;
				status_q <= ST_TOO_LONG;
			end else if (full) begin
				hit_q    <= 1'b0;
				status_q <= ST_FULL;
			end else begin
				hit_q    <= 1'b0;
				status_q <= ST_STORED;
			end
		end
		if (state_q == S_DRAIN) begin
			hit_q    <= hit_acc_q || hit_now;
			status_q <= ST_ANSWERED;
		end
	end

	assign done   = done_q;
	assign hit    = hit_q;
	assign status = status_q;

endmodule

>>> design/picc_checker.sv
`include "assert_macros.svh"

module picc_checker import picc_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       command,
	input logic       last,
	input logic       done,
	input logic       hit,
	input logic [1:0] status
);

	// Results only ever appear once the sweep is over
	`PICC_ASSERT(a_done_idle, done |-> !busy, "result strobe while busy")
	// Insert results never report a hit
	`PICC_ASSERT(a_insert_no_hit, (done && status != ST_ANSWERED) |-> !hit, "hit on insert")
	// Only a query transfer starts a sweep
	`PICC_ASSERT(a_busy_query, $rose(busy) |-> $past(start && command), "busy without query")
	// After an insert node the block is not busy in the next cycle
	`PICC_ASSERT_NEXT(a_insert_fast, start && !busy && !command, !busy, "insert stalled")
	// A node that is not the last one gives no result
	`PICC_ASSERT_NEXT(a_no_early, start && !busy && !last, !done, "result before last node")

endmodule

bind path_interval_containment_cache_unit picc_checker u_picc_checker (.*);

>>> tb/picc_tb_pkg.sv
`timescale 1ns / 100ps

package picc_tb_pkg;

	// Node command codes as seen on the command port.
	typedef enum logic {
		CMD_INSERT = 1'b0,
		CMD_QUERY  = 1'b1
	} command_t;

endpackage

>>> tb/picc_checker.sv
`timescale 1ns / 100ps

module picc_scoreboard
	import picc_pkg::*;
	import picc_tb_pkg::*;
#(
	parameter int ENTRIES    = 64,
	parameter int MAX_NODES  = 16,
	parameter int POINT_BITS = 16,
	parameter int TIME_BITS  = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic                  busy,
	input  logic                  command,
	input  logic [POINT_BITS-1:0] point_id,
	input  logic [TIME_BITS-1:0]  time_min,
	input  logic [TIME_BITS-1:0]  time_max,
	input  logic                  last,
	input  logic                  done,
	input  logic                  hit,
	input  logic [1:0]            status,
	output int                    fail_count,
	output int                    pending,
	output int                    results_seen,
	output int                    hits_seen
);

	typedef struct packed {
		logic    hit;
		status_t status;
	} outcome_t;

	bit [POINT_BITS-1:0] point_tab [ENTRIES][MAX_NODES];
	bit [TIME_BITS-1:0]  lo_tab    [ENTRIES][MAX_NODES];
	bit [TIME_BITS-1:0]  hi_tab    [ENTRIES][MAX_NODES];
	int                  len_tab   [ENTRIES];
	int                  entry_total;
	int                  node_idx;
	bit [ENTRIES-1:0]    candidates;
	bit                  overflow;
	outcome_t            outcome_q [$];
	outcome_t            oldest;

	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $time, msg);
		fail_count++;
	endtask

	// One accepted node: update path state, queue the outcome on a last node.
	task automatic predict_node(input command_t cmd, input bit [POINT_BITS-1:0] pid,
			input bit [TIME_BITS-1:0] lo, input bit [TIME_BITS-1:0] hi, input bit fin);
		outcome_t o;
		if (node_idx >= MAX_NODES) begin
			overflow = 1'b1;
		end else if (cmd == CMD_INSERT) begin
			if (entry_total < ENTRIES) begin
				point_tab[entry_total][node_idx] = pid;
				lo_tab[entry_total][node_idx]    = lo;
				hi_tab[entry_total][node_idx]    = hi;
			end
		end else begin
			// length test first, so rows past an entry's end are never read
			for (int e = 0; e < entry_total; e++)
				if (candidates[e] && (len_tab[e] <= node_idx || point_tab[e][node_idx] != pid ||
						lo < lo_tab[e][node_idx] || hi > hi_tab[e][node_idx]))
					candidates[e] = 1'b0;
		end
		if (node_idx < MAX_NODES)
			node_idx++;
		if (fin) begin
			o.hit = 1'b0;
			if (cmd == CMD_INSERT) begin
				if (overflow) begin
					o.status = ST_TOO_LONG;
				end else if (entry_total >= ENTRIES) begin
					o.status = ST_FULL;
				end else begin
					len_tab[entry_total] = node_idx;
					entry_total++;
					o.status = ST_STORED;
				end
			end else begin
				o.status = ST_ANSWERED;
				if (!overflow)
					for (int e = 0; e < entry_total; e++)
						if (candidates[e] && len_tab[e] == node_idx)
							o.hit = 1'b1;
			end
			outcome_q.insert(outcome_q.size(), o);
			node_idx   = 0;
			overflow   = 1'b0;
			candidates = '1;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_total  = 0;
			node_idx     = 0;
			overflow     = 1'b0;
			candidates   = '1;
			outcome_q.delete();
			fail_count   = 0;
			results_seen = 0;
			hits_seen    = 0;
			pending     <= 0;
		end else begin
			// results first: a strobe in this cycle never belongs to this edge's transfer
			if (done) begin
				results_seen++;
				if (outcome_q.size() == 0) begin
					report_mismatch($sformatf("result hit=%0b status=%0d with nothing expected",
						hit, status));
				end else begin
					oldest = outcome_q.pop_front();
					if (hit !== oldest.hit)
						report_mismatch($sformatf("hit %b, expected %b", hit, oldest.hit));
					if (status !== oldest.status)
						report_mismatch($sformatf("status %0d, expected %0d", status,
							oldest.status));
					if (oldest.hit)
						hits_seen++;
				end
			end
			if (start && !busy)
				predict_node(command_t'(command), point_id, time_min, time_max, last);
			pending <= outcome_q.size();
		end
	end

endmodule

>>> tb/path_interval_containment_cache_unit_tb.sv
`timescale 1ns / 100ps

module path_interval_containment_cache_unit_tb;
	import picc_pkg::*;
	import picc_tb_pkg::*;

	localparam int ENTRIES     = 64;
	localparam int MAX_NODES   = 16;
	localparam int POINT_BITS  = 16;
	localparam int TIME_BITS   = 32;
	localparam int PATH_MAX    = MAX_NODES + 3;   // room for overlong paths
	localparam int ITEM_TARGET = 1750;
	localparam int CALM_FROM   = 1500;            // no sender idling past this many nodes
	localparam int DRAIN_EVERY = 300;             // sender waits for all outcomes this often
	localparam int TAIL_CYCLES = ENTRIES + 16;    // longest query scan plus margin
	localparam int IDLE_LIMIT  = 4000;            // watchdog: cycles with no transfer or result

	typedef enum int {
		FILL_INSERT,
		FILL_QUERY,
		FILL_MIXED
	} fill_t;

	logic                  clk;
	logic                  arst_n;
	logic                  start;
	logic                  busy;
	logic                  command;
	logic [POINT_BITS-1:0] point_id;
	logic [TIME_BITS-1:0]  time_min;
	logic [TIME_BITS-1:0]  time_max;
	logic                  last;
	logic                  done;
	logic                  hit;
	logic [1:0]            status;

	int fail_count;
	int pending;
	int results_seen;
	int hits_seen;
	int items_sent;
	int idle_cycles;
	bit gaps_on;

	// Shadow of what the table holds, kept only to steer stimulus towards hits
	// and away from committing an entry with an unwritten node.
	bit [POINT_BITS-1:0] tab_point [ENTRIES][MAX_NODES];
	bit [TIME_BITS-1:0]  tab_lo    [ENTRIES][MAX_NODES];
	bit [TIME_BITS-1:0]  tab_hi    [ENTRIES][MAX_NODES];
	int                  tab_len   [ENTRIES];
	int                  tab_count;
	int                  path_pos;
	bit                  path_over;
	bit [MAX_NODES-1:0]  row_written;   // node slots of the next free entry written so far

	// Path under construction.
	command_t            path_cmd   [PATH_MAX];
	bit [POINT_BITS-1:0] path_point [PATH_MAX];
	bit [TIME_BITS-1:0]  path_lo    [PATH_MAX];
	bit [TIME_BITS-1:0]  path_hi    [PATH_MAX];
	int                  path_len;

	initial clk = 1'b0;
	always #2 clk = ~clk;

	path_interval_containment_cache_unit #(
		.ENTRIES    (ENTRIES),
		.MAX_NODES  (MAX_NODES),
		.POINT_BITS (POINT_BITS),
		.TIME_BITS  (TIME_BITS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.command  (command),
		.point_id (point_id),
		.time_min (time_min),
		.time_max (time_max),
		.last     (last),
		.done     (done),
		.hit      (hit),
		.status   (status)
	);

	picc_scoreboard #(
		.ENTRIES    (ENTRIES),
		.MAX_NODES  (MAX_NODES),
		.POINT_BITS (POINT_BITS),
		.TIME_BITS  (TIME_BITS)
	) u_scoreboard (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.command      (command),
		.point_id     (point_id),
		.time_min     (time_min),
		.time_max     (time_max),
		.last         (last),
		.done         (done),
		.hit          (hit),
		.status       (status),
		.fail_count   (fail_count),
		.pending      (pending),
		.results_seen (results_seen),
		.hits_seen    (hits_seen)
	);

	// Watchdog: a long run of cycles with neither a transfer nor a result means a hang.
	always @(posedge clk) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else if ((start && !busy) || done) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("[%0t] watchdog: no transfer or result for %0d cycles, %0d outcomes due",
					$time, IDLE_LIMIT, pending);
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	// Shadow update for one transferred node; mirrors the insert side of the block.
	task automatic track_row(input command_t cmd, input bit [POINT_BITS-1:0] pid,
			input bit [TIME_BITS-1:0] lo, input bit [TIME_BITS-1:0] hi, input bit fin);
		if (path_pos >= MAX_NODES) begin
			path_over = 1'b1;
		end else if (cmd == CMD_INSERT && tab_count < ENTRIES) begin
			tab_point[tab_count][path_pos] = pid;
			tab_lo[tab_count][path_pos]    = lo;
			tab_hi[tab_count][path_pos]    = hi;
			row_written[path_pos]          = 1'b1;
		end
		if (path_pos < MAX_NODES)
			path_pos++;
		if (fin) begin
			if (cmd == CMD_INSERT && !path_over && tab_count < ENTRIES) begin
				tab_len[tab_count] = path_pos;
				tab_count++;
				row_written = '0;
			end
			path_pos  = 0;
			path_over = 1'b0;
		end
	endtask

	// Drive one node and hold it until the transfer; optional idle burst afterwards.
	// start is only lowered in the step of the transfer, never re-raised in that step.
	task automatic send_node(input command_t cmd, input bit [POINT_BITS-1:0] pid,
			input bit [TIME_BITS-1:0] lo, input bit [TIME_BITS-1:0] hi, input bit fin);
		start    <= 1'b1;
		command  <= cmd;
		point_id <= pid;
		time_min <= lo;
		time_max <= hi;
		last     <= fin;
		do
			@(posedge clk);
		while (busy);
		track_row(cmd, pid, lo, hi, fin);
		items_sent++;
		if (gaps_on && items_sent < CALM_FROM && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
	endtask

	// Sender holds off until every outstanding outcome has been seen.
	// It waits for a clock edge first so the checker's count includes the last transfer.
	task automatic wait_drained();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	task automatic send_path();
		for (int i = 0; i < path_len; i++)
			send_node(path_cmd[i], path_point[i], path_lo[i], path_hi[i], i == path_len - 1);
	endtask

	task automatic pick_window(output bit [TIME_BITS-1:0] lo, output bit [TIME_BITS-1:0] hi);
		bit [TIME_BITS-1:0] a;
		bit [TIME_BITS-1:0] b;
		a = $urandom;
		b = $urandom;
		case ($urandom_range(0, 7))
			0: a = '0;
			1: b = '1;
			default: ;
		endcase
		lo = (a < b) ? a : b;
		hi = (a < b) ? b : a;
	endtask

	// Random path; narrow point ids make different entries share prefixes.
	task automatic build_random(input int len, input fill_t fill);
		bit narrow;
		narrow   = ($urandom_range(0, 1) == 1);
		path_len = len;
		for (int i = 0; i < len; i++) begin
			case (fill)
				FILL_INSERT: path_cmd[i] = CMD_INSERT;
				FILL_QUERY:  path_cmd[i] = CMD_QUERY;
				default:     path_cmd[i] = command_t'($urandom_range(0, 1));
			endcase
			path_point[i] = narrow ? POINT_BITS'($urandom_range(0, 3)) :
				POINT_BITS'($urandom_range(0, (1 << POINT_BITS) - 1));
			pick_window(path_lo[i], path_hi[i]);
		end
	endtask

	// Query built from a stored entry: windows inside the entry's, then often a
	// near miss (one bound one step out, one point bit flipped, length off by one).
	task automatic build_probe();
		int                 e;
		int                 k;
		int                 b;
		bit [TIME_BITS-1:0] span;
		e        = $urandom_range(0, tab_count - 1);
		path_len = tab_len[e];
		for (int i = 0; i < path_len; i++) begin
			path_cmd[i]   = CMD_QUERY;
			path_point[i] = tab_point[e][i];
			path_lo[i]    = tab_lo[e][i];
			path_hi[i]    = tab_hi[e][i];
			if ($urandom_range(0, 2) != 0) begin
				span       = tab_hi[e][i] - tab_lo[e][i];
				path_lo[i] = tab_lo[e][i] + $urandom % (span / 2 + 1);
				path_hi[i] = tab_hi[e][i] - $urandom % (span / 2 + 1);
			end
		end
		if ($urandom_range(0, 1) == 1) begin
			k = $urandom_range(0, path_len - 1);
			case ($urandom_range(0, 4))
				0: if (tab_lo[e][k] != '0) path_lo[k] = tab_lo[e][k] - 1;
				1: if (tab_hi[e][k] != '1) path_hi[k] = tab_hi[e][k] + 1;
				2: begin
					b = $urandom_range(0, POINT_BITS - 1);
					path_point[k][b] = ~path_point[k][b];
				end
				3: if (path_len > 1) path_len--;
				default: begin
					path_cmd[path_len]   = CMD_QUERY;
					path_point[path_len] = POINT_BITS'($urandom_range(0, 3));
					pick_window(path_lo[path_len], path_hi[path_len]);
					path_len++;
				end
			endcase
		end
	endtask

	// A mixed path ending in an insert would commit an entry whose query-node
	// slots were never written; end such a path on a query node instead.
	task automatic seal_path();
		bit covered;
		covered = 1'b1;
		if (path_cmd[path_len-1] == CMD_INSERT && path_len <= MAX_NODES && tab_count < ENTRIES) begin
			for (int i = 0; i < path_len; i++)
				if (!row_written[i] && path_cmd[i] != CMD_INSERT)
					covered = 1'b0;
			if (!covered)
				path_cmd[path_len-1] = CMD_QUERY;
		end
	endtask

	initial begin
		int kind;
		int next_drain;

		arst_n      = 1'b0;
		start       = 1'b0;
		command     = CMD_INSERT;
		point_id    = '0;
		time_min    = '0;
		time_max    = '0;
		last        = 1'b0;
		items_sent  = 0;
		tab_count   = 0;
		path_pos    = 0;
		path_over   = 1'b0;
		row_written = '0;
		gaps_on     = 1'b1;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: query on an empty table
		send_node(CMD_QUERY, 16'h1234, '0, '1, 1'b1);
		// full-range window at the top point id, then an exact-bounds query on it
		send_node(CMD_INSERT, 16'hFFFF, '0, '1, 1'b1);
		send_node(CMD_QUERY, 16'hFFFF, '0, '1, 1'b1);
		// window [1.0, 2.0] at point 0: min one step low, max one step high, then a point inside
		send_node(CMD_INSERT, 16'h0000, 32'h0001_0000, 32'h0002_0000, 1'b1);
		send_node(CMD_QUERY, 16'h0000, 32'h0000_FFFF, 32'h0002_0000, 1'b1);
		send_node(CMD_QUERY, 16'h0000, 32'h0001_0000, 32'h0002_0001, 1'b1);
		send_node(CMD_QUERY, 16'h0000, 32'h0001_0000, 32'h0001_0000, 1'b1);
		// overlong insert, one node past the limit
		build_random(MAX_NODES + 1, FILL_INSERT);
		send_path();
		wait_drained();

		// Random: mostly stored-entry probes and well-formed inserts, some mixed,
		// overlong and unrelated query paths.
		next_drain = items_sent + DRAIN_EVERY;
		while (items_sent < ITEM_TARGET) begin
			gaps_on = ($urandom_range(0, 2) != 0);
			kind    = $urandom_range(0, 19);
			if (kind < 6 && (tab_count < ENTRIES || kind == 0))
				build_random(($urandom_range(0, 7) == 0) ? MAX_NODES : $urandom_range(1, 4),
					FILL_INSERT);
			else if (kind < 14 && tab_count > 0)
				build_probe();
			else if (kind < 17)
				build_random($urandom_range(1, 5), FILL_MIXED);
			else if (kind < 18)
				build_random($urandom_range(MAX_NODES + 1, PATH_MAX),
					$urandom_range(0, 1) ? FILL_INSERT : FILL_QUERY);
			else
				build_random($urandom_range(1, 4), FILL_QUERY);
			seal_path();
			send_path();
			if (items_sent >= next_drain && items_sent < CALM_FROM) begin
				wait_drained();
				next_drain += DRAIN_EVERY;
			end
		end

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Run covered %0d path nodes, %0d outcomes checked, %0d query hits, %0d entries stored.",
			items_sent, results_seen, hits_seen, tab_count);
		$display("Included window-edge queries, overlong and table-full inserts, mixed-command paths.");
		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

>>> path_interval_containment_cache_unit.f
+incdir+design
design/picc_pkg.sv
design/picc_ram.sv
design/path_interval_containment_cache_unit.sv
design/picc_checker.sv
tb/picc_tb_pkg.sv
tb/picc_checker.sv
tb/path_interval_containment_cache_unit_tb.sv
